/* src/tkrd_pkg.sv */
// Shared types and constants for the touch key region detector.
`default_nettype none

package tkrd_pkg;

    localparam int MAX_KEYS = 16;
    localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_EN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD   = 2'd3;

    localparam logic [15:0] MIN_HOLD_RESET = 16'd10;

    typedef enum logic [1:0] {
        CMD_TOUCH = 2'd0,
        CMD_REG   = 2'd1,
        CMD_UNREG = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHRD,
        S_SHWR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [15:0] bottom;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] left;
    } t_rect;

    typedef struct packed {
        logic [15:0] id;
        t_rect       rect;
        logic [31:0] ptime;
    } t_entry;

endpackage

`default_nettype wire

/* src/touch_key_region_detector_core.sv */
// Touch key region detector: key rectangle table and touch-to-event logic.
`default_nettype none

// The key table (id, rectangle, press time) lives in one synchronous RAM of
// MAX_KEYS entries with a registered read; only the first entry-count entries
// are ever read, so the RAM needs no clearing after reset.
// One input transaction is worked at a time; the input stalls from the
// accept edge until the result has been handed to the output register.
// Register, unregister and touch samples that need a lookup walk the table
// one entry per cycle, reads pipelined against the compare, and stop at the
// first match or after the last entry. An unregister then moves each
// following entry down by one, reading it and writing it back, and then
// lowers the entry count. Clear, refused registers and samples with nothing
// to do skip the RAM. Every transaction ends by handing its result to the
// output register, and the core then returns to idle before it takes the
// next input; that input is taken while the result still waits there. The
// longest transaction is the unregister of the first entry of a full table.
// Configuration writes land at once and should only be made while idle.
module touch_key_region_detector_core
    import tkrd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [15:0]          i_key_id,
    input  wire logic [15:0]          i_left,
    input  wire logic [15:0]          i_top,
    input  wire logic [15:0]          i_right,
    input  wire logic [15:0]          i_bottom,
    input  wire logic [15:0]          i_touch_x,
    input  wire logic [15:0]          i_touch_y,
    input  wire logic [31:0]          i_now_ticks,

    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_pressed,
    output logic                      o_released,
    output logic                      o_clicked,
    output logic [15:0]               o_event_key,
    output logic                      o_status,

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    // key table RAM
    t_entry r_mem [MAX_KEYS];
    t_entry r_rd_data;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_entry           mem_wd;
    logic             mem_re;
    logic [IDX_W-1:0] mem_ra;

    // control
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_held, n_held;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;

    // latched transaction
    t_cmd        r_cmd, n_cmd;
    logic [15:0] r_key, n_key;
    t_rect       r_rect, n_rect;
    logic [15:0] r_tx, n_tx;
    logic [15:0] r_ty, n_ty;
    logic [31:0] r_now, n_now;

    // pending result
    logic        r_pe, n_pe;
    logic        r_re, n_re;
    logic        r_ce, n_ce;
    logic [15:0] r_ek, n_ek;
    logic        r_st, n_st;

    // output register
    logic        r_out_vld, n_out_vld;
    logic        r_o_pe, n_o_pe;
    logic        r_o_re, n_o_re;
    logic        r_o_ce, n_o_ce;
    logic [15:0] r_o_ek, n_o_ek;
    logic        r_o_st, n_o_st;

    // configuration
    logic        r_press_en, r_release_en, r_click_en;
    logic [15:0] r_min_hold;

    logic        in_acc;
    logic        out_free;
    logic        any_en;
    logic        touched;
    logic        go_scan;
    logic        scan_press;
    logic [15:0] search_id;
    logic        hit;
    logic        match;
    logic        scan_end;
    logic [31:0] hold_end;
    logic        qualify;
    logic [CNT_W-1:0] idx_m1;
    t_cmd        in_cmd;

    assign in_cmd   = t_cmd'(i_cmd);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign any_en   = r_press_en || r_release_en || r_click_en;
    assign touched  = (i_touch_x != 16'd0) && (i_touch_y != 16'd0);

    // decide at accept whether the transaction needs a table walk
    always_comb begin
        go_scan = 1'b0;
        unique case (in_cmd)
            CMD_REG:   go_scan = (i_key_id != 16'd0) && (r_count != MAX_CNT);
            CMD_UNREG: go_scan = 1'b1;
            CMD_CLEAR: go_scan = 1'b0;
            CMD_TOUCH: go_scan = (r_count != '0) && any_en &&
                                 ((touched && r_held == 16'd0) ||
                                  (!touched && r_held != 16'd0));
            default:   go_scan = 1'b0;
        endcase
    end

    // table walk compare: rectangle hit for a press, id match otherwise
    assign scan_press = (r_cmd == CMD_TOUCH) && (r_held == 16'd0);
    assign search_id  = (r_cmd == CMD_TOUCH) ? r_held : r_key;
    assign hit = scan_press ?
                 ((r_tx >= r_rd_data.rect.left) && (r_tx <= r_rd_data.rect.right) &&
                  (r_ty >= r_rd_data.rect.top)  && (r_ty <= r_rd_data.rect.bottom)) :
                 (r_rd_data.id == search_id);
    assign match    = r_chk_vld && hit;
    assign scan_end = !r_chk_vld && (r_idx >= r_count);

    // release needs a nonzero press time and hold end (mod 2^32) before now
    assign hold_end = r_rd_data.ptime + {16'd0, r_min_hold};
    assign qualify  = (r_rd_data.ptime != 32'd0) && (hold_end < r_now);

    assign idx_m1 = r_idx - CNT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = go_scan ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = (r_cmd == CMD_UNREG) ? S_SHRD : S_EMIT;
                end else if (scan_end) begin
                    n_state = S_EMIT;
                end
            end
            S_SHRD: begin
                n_state = (r_idx < r_count) ? S_SHWR : S_EMIT;
            end
            S_SHWR: begin
                n_state = S_SHRD;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_count   = r_count;
        n_held    = r_held;
        n_idx     = r_idx;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_rect    = r_rect;
        n_tx      = r_tx;
        n_ty      = r_ty;
        n_now     = r_now;
        n_pe      = r_pe;
        n_re      = r_re;
        n_ce      = r_ce;
        n_ek      = r_ek;
        n_st      = r_st;
        n_out_vld = r_out_vld && i_out_stall;
        n_o_pe    = r_o_pe;
        n_o_re    = r_o_re;
        n_o_ce    = r_o_ce;
        n_o_ek    = r_o_ek;
        n_o_st    = r_o_st;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = r_rd_data;
        mem_re    = 1'b0;
        mem_ra    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd     = in_cmd;
                    n_key     = i_key_id;
                    n_rect    = '{bottom: i_bottom, right: i_right, top: i_top, left: i_left};
                    n_tx      = i_touch_x;
                    n_ty      = i_touch_y;
                    n_now     = i_now_ticks;
                    n_pe      = 1'b0;
                    n_re      = 1'b0;
                    n_ce      = 1'b0;
                    n_ek      = 16'd0;
                    n_st      = 1'b0;
                    n_idx     = '0;
                    n_chk_vld = 1'b0;
                    if (in_cmd == CMD_REG && !go_scan) begin
                        n_st = 1'b1;
                    end
                    if (in_cmd == CMD_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            S_SCAN: begin
                if (match) begin
                    unique case (r_cmd)
                        CMD_REG: begin
                            n_st = 1'b1;  // duplicate id
                        end
                        CMD_UNREG: begin
                            n_idx = CNT_W'(r_chk_idx) + CNT_W'(1);
                        end
                        CMD_TOUCH: begin
                            if (scan_press) begin
                                mem_we       = 1'b1;
                                mem_wa       = r_chk_idx;
                                mem_wd.ptime = r_now;
                                n_held       = r_rd_data.id;
                                if (r_press_en) begin
                                    n_pe = 1'b1;
                                    n_ek = r_rd_data.id;
                                end
                            end else begin
                                if (qualify) begin
                                    mem_we       = 1'b1;
                                    mem_wa       = r_chk_idx;
                                    mem_wd.ptime = 32'd0;
                                    n_re         = r_release_en;
                                    n_ce         = r_click_en;
                                    if (r_release_en || r_click_en) begin
                                        n_ek = r_held;
                                    end
                                end
                                n_held = 16'd0;
                            end
                        end
                        default: ;
                    endcase
                    n_chk_vld = 1'b0;
                end else if (scan_end) begin
                    if (r_cmd == CMD_REG) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[IDX_W-1:0];
                        mem_wd  = '{id: r_key, rect: r_rect, ptime: 32'd0};
                        n_count = r_count + CNT_W'(1);
                    end else if (r_cmd == CMD_TOUCH && !scan_press) begin
                        n_held = 16'd0;  // held key no longer in the table
                    end
                end else begin
                    if (r_idx < r_count) begin
                        mem_re    = 1'b1;
                        mem_ra    = r_idx[IDX_W-1:0];
                        n_idx     = r_idx + CNT_W'(1);
                        n_chk_vld = 1'b1;
                        n_chk_idx = r_idx[IDX_W-1:0];
                    end else begin
                        n_chk_vld = 1'b0;
                    end
                end
            end
            S_SHRD: begin
                if (r_idx < r_count) begin
                    mem_re = 1'b1;
                    mem_ra = r_idx[IDX_W-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_SHWR: begin
                mem_we = 1'b1;
                mem_wa = idx_m1[IDX_W-1:0];
                mem_wd = r_rd_data;
                n_idx  = r_idx + CNT_W'(1);
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_o_pe    = r_pe;
                    n_o_re    = r_re;
                    n_o_ce    = r_ce;
                    n_o_ek    = r_ek;
                    n_o_st    = r_st;
                end
            end
            default: ;
        endcase
    end

    // RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_held    <= 16'd0;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_held    <= n_held;
            r_idx     <= n_idx;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_rect    <= n_rect;
        r_tx      <= n_tx;
        r_ty      <= n_ty;
        r_now     <= n_now;
        r_pe      <= n_pe;
        r_re      <= n_re;
        r_ce      <= n_ce;
        r_ek      <= n_ek;
        r_st      <= n_st;
        r_o_pe    <= n_o_pe;
        r_o_re    <= n_o_re;
        r_o_ce    <= n_o_ce;
        r_o_ek    <= n_o_ek;
        r_o_st    <= n_o_st;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_en   <= 1'b1;
            r_release_en <= 1'b1;
            r_click_en   <= 1'b1;
            r_min_hold   <= MIN_HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRESS_EN:   r_press_en   <= i_cfg_data[0];
                CFG_RELEASE_EN: r_release_en <= i_cfg_data[0];
                CFG_CLICK_EN:   r_click_en   <= i_cfg_data[0];
                CFG_MIN_HOLD:   r_min_hold   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_pressed   = r_o_pe;
    assign o_released  = r_o_re;
    assign o_clicked   = r_o_ce;
    assign o_event_key = r_o_ek;
    assign o_status    = r_o_st;

endmodule

`default_nettype wire
